FILE: design/crs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types, codes and the request transition check of the
// crash-recovery supervisor.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int STAMP_W = 32;
    localparam int STATE_W = 4;
    localparam int STATUS_W = 3;
    localparam int CFG_INDEX_W = 2;

    // Machine state codes.
    localparam logic [STATE_W-1:0] MS_IDLE = 4'd0;
    localparam logic [STATE_W-1:0] MS_PRINTING = 4'd1;
    localparam logic [STATE_W-1:0] MS_STALL = 4'd2;
    localparam logic [STATE_W-1:0] MS_POWER = 4'd3;
    localparam logic [STATE_W-1:0] MS_TOOLFALL = 4'd4;
    localparam logic [STATE_W-1:0] MS_TOOLCRASH = 4'd5;
    localparam logic [STATE_W-1:0] MS_HOMEFAIL = 4'd6;
    localparam logic [STATE_W-1:0] MS_WAIT = 4'd7;
    localparam logic [STATE_W-1:0] MS_RECOVERY = 4'd8;
    localparam logic [STATE_W-1:0] MS_REPLAY = 4'd9;
    localparam logic [STATE_W-1:0] MS_SELFTEST = 4'd10;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_SAME = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ACTIVE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_HALTED = 3'd4;

    // Request kinds.
    localparam logic REQ_STATE = 1'b0;
    localparam logic REQ_CRASH = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DETECTION_ENABLED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY_WINDOW = 2'd1;

    // Scan token that walks down the row of history cells.
    typedef struct packed {
        logic               live;
        logic [STAMP_W-1:0] now;
        logic               all_recent;
    } crs_token_t;

    // Outcome of a state request.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STATE_W-1:0]  state;
        logic                tool_event;
        logic                active;
        logic                repeated;
        logic                clear_hist;
    } crs_req_result_t;

    function automatic crs_req_result_t crs_eval_request(
        input logic [STATE_W-1:0] cur,
        input logic               act,
        input logic               tev,
        input logic               rep,
        input logic               det,
        input logic [STATE_W-1:0] ns,
        input logic               busy
    );
        crs_req_result_t r;
        logic            can_trig;
        r.status     = STATUS_OK;
        r.state      = ns;
        r.tool_event = tev;
        r.active     = act;
        r.repeated   = rep;
        r.clear_hist = 1'b0;
        can_trig     = (cur == MS_PRINTING) && act;
        if (ns == cur) begin
            r.status = STATUS_SAME;
        end else begin
            unique case (ns)
                MS_IDLE, MS_SELFTEST: begin
                    r.clear_hist = 1'b1;
                    r.repeated   = 1'b0;
                    r.active     = 1'b0;
                end
                MS_STALL: begin
                    if (!can_trig || !det) r.status = STATUS_NOT_ACTIVE;
                    r.tool_event = busy;
                end
                MS_POWER: begin
                    r.tool_event = busy;
                end
                MS_TOOLFALL, MS_TOOLCRASH: begin
                    if (!can_trig) r.status = STATUS_NOT_ACTIVE;
                    r.tool_event = 1'b1;
                end
                MS_HOMEFAIL: begin
                    if (!can_trig) r.status = STATUS_NOT_ACTIVE;
                    r.tool_event = 1'b0;
                end
                MS_WAIT: begin
                    if (cur != MS_PRINTING && cur != MS_TOOLCRASH && cur != MS_HOMEFAIL)
                        r.status = STATUS_INVALID;
                end
                MS_RECOVERY: begin
                    if (cur != MS_PRINTING && cur != MS_STALL && cur != MS_TOOLFALL
                        && cur != MS_POWER)
                        r.status = STATUS_INVALID;
                end
                MS_REPLAY: begin
                    if (cur != MS_RECOVERY) r.status = STATUS_INVALID;
                    r.active = 1'b1;
                end
                MS_PRINTING: begin
                    if (cur != MS_RECOVERY && cur != MS_WAIT && cur != MS_IDLE
                        && cur != MS_REPLAY)
                        r.status = STATUS_INVALID;
                    r.repeated = 1'b0;
                    if (cur != MS_REPLAY) r.active = 1'b1;
                end
                default: begin
                    r.status = STATUS_INVALID;
                end
            endcase
        end
        // A fault leaves everything as it was; the caller sets the halt.
        if (r.status != STATUS_OK) begin
            r.state      = cur;
            r.tool_event = tev;
            r.active     = act;
            r.repeated   = rep;
            r.clear_hist = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: design/crs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_cell
// One slot of the crash history: ages its timestamp when the scan token
// passes and takes the new timestamp when it is the write slot.
// ----------------------------------------------------------------------------
module crs_cell
    import crs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear_i,
    input  logic [STAMP_W-1:0] window_i,
    input  logic               slot_hit_i,
    input  crs_token_t         tok_i,
    output crs_token_t         tok_o
);

    logic [STAMP_W-1:0] stamp_reg;
    logic               valid_reg;
    logic               live_reg;
    logic [STAMP_W-1:0] now_reg;
    logic               all_recent_reg;
    logic [STAMP_W-1:0] age;
    logic               recent;

    // Ages wrap modulo 2^32, so a plain subtraction is the right measure.
    assign age    = tok_i.now - stamp_reg;
    assign recent = valid_reg && (age <= window_i);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            live_reg  <= 1'b0;
        end else begin
            live_reg <= tok_i.live;
            if (clear_i) begin
                valid_reg <= 1'b0;
            end else if (tok_i.live) begin
                valid_reg <= slot_hit_i ? 1'b1 : recent;
            end
        end
    end

    always_ff @(posedge aclk) begin
        now_reg        <= tok_i.now;
        all_recent_reg <= tok_i.all_recent && recent;
        if (tok_i.live && slot_hit_i) begin
            stamp_reg <= tok_i.now;
        end
    end

    assign tok_o.live       = live_reg;
    assign tok_o.now        = now_reg;
    assign tok_o.all_recent = all_recent_reg;

endmodule

FILE: design/crash_recovery_supervisor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crash_recovery_supervisor_top
// Crash-recovery supervisor: state request checking and crash history.
// ----------------------------------------------------------------------------
// Every input transaction produces exactly one result transaction. A state
// request is checked in the cycle it is accepted; its status and new state
// are registered and then moved into the output register. A crash event
// sends a scan token down a row of HISTORY_DEPTH history cells, one cell per
// clock, and its result moves into the output register after the token has
// left the last cell. The input side takes a new transaction as soon as the
// previous one has moved into the output register, even while that result
// still waits for m_ready. Once a request is refused (same state, trigger
// while not active or invalid transition) the block halts and answers every
// later transaction with the halted status until reset. Configuration writes
// are always ready and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module crash_recovery_supervisor_top
    import crs_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [STAMP_W-1:0]     cfg_data,

    // Input transaction channel.
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_req_type,
    input  logic [STATE_W-1:0]     s_new_state,
    input  logic                   s_tool_change_busy,
    input  logic [STAMP_W-1:0]     s_now_time,

    // Result transaction channel.
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_W-1:0]    m_status,
    output logic [STATE_W-1:0]     m_current_state,
    output logic                   m_tool_event,
    output logic                   m_is_active_flag,
    output logic                   m_crash_repeat
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    // Sequencer phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SCAN = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [1:0]          phase_reg;
    logic                det_en_reg;
    logic [STAMP_W-1:0]  window_reg;
    logic [STATE_W-1:0]  state_reg;
    logic                active_reg;
    logic                tool_event_reg;
    logic                repeated_reg;
    logic                halted_reg;
    logic [SLOT_W-1:0]   write_slot_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [STATE_W-1:0]  m_state_reg;
    logic                m_tool_event_reg;
    logic                m_active_reg;
    logic                m_repeated_reg;

    logic            in_accept;
    logic            out_load;
    logic            do_request;
    logic            hist_clear;
    crs_req_result_t req_res;
    crs_token_t      tok [HISTORY_DEPTH+1];

    assign cfg_ready = 1'b1;
    assign s_ready   = (phase_reg == PH_IDLE);
    assign in_accept = s_valid && s_ready;

    // The output register loads a finished result when it is empty or its content is leaving.
    assign out_load = (phase_reg == PH_DONE) && (!m_valid_reg || m_ready);

    assign req_res = crs_eval_request(state_reg, active_reg, tool_event_reg,
                                      repeated_reg, det_en_reg, s_new_state,
                                      s_tool_change_busy);

    assign do_request = in_accept && !halted_reg && (s_req_type == REQ_STATE);
    assign hist_clear = do_request && req_res.clear_hist;

    // The scan token enters the first cell in the cycle the crash event is
    // accepted, and every cell checks its stamp against the window in turn.
    assign tok[0].live       = in_accept && !halted_reg && (s_req_type == REQ_CRASH);
    assign tok[0].now        = s_now_time;
    assign tok[0].all_recent = 1'b1;

    for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
        crs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .clear_i    (hist_clear),
            .window_i   (window_reg),
            .slot_hit_i (write_slot_reg == SLOT_W'(i)),
            .tok_i      (tok[i]),
            .tok_o      (tok[i+1])
        );
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_en_reg <= 1'b1;
            window_reg <= STAMP_W'(60);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_DETECTION_ENABLED) det_en_reg <= cfg_data[0];
            if (cfg_index == CFG_HISTORY_WINDOW) window_reg <= cfg_data;
        end
    end

    // Supervisor state and sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            state_reg      <= MS_IDLE;
            active_reg     <= 1'b0;
            tool_event_reg <= 1'b0;
            repeated_reg   <= 1'b0;
            halted_reg     <= 1'b0;
            write_slot_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (in_accept) begin
                        if (halted_reg) begin
                            phase_reg <= PH_DONE;
                        end else if (s_req_type == REQ_CRASH) begin
                            phase_reg <= PH_SCAN;
                        end else begin
                            phase_reg      <= PH_DONE;
                            state_reg      <= req_res.state;
                            active_reg     <= req_res.active;
                            tool_event_reg <= req_res.tool_event;
                            repeated_reg   <= req_res.repeated;
                            if (req_res.status != STATUS_OK) halted_reg <= 1'b1;
                            if (req_res.clear_hist) write_slot_reg <= '0;
                        end
                    end
                end
                PH_SCAN: begin
                    if (tok[HISTORY_DEPTH].live) begin
                        phase_reg <= PH_DONE;
                        if (tok[HISTORY_DEPTH].all_recent) repeated_reg <= 1'b1;
                        write_slot_reg <= (write_slot_reg == LAST_SLOT) ? '0
                                        : write_slot_reg + SLOT_W'(1);
                    end
                end
                PH_DONE: begin
                    if (out_load) begin
                        phase_reg <= PH_IDLE;
                    end
                end
                default: begin
                    phase_reg <= PH_IDLE;
                end
            endcase
            // A new result keeps the output full; otherwise it empties when taken.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            if (halted_reg) begin
                status_reg <= STATUS_HALTED;
            end else if (s_req_type == REQ_CRASH) begin
                status_reg <= STATUS_OK;
            end else begin
                status_reg <= req_res.status;
            end
        end
        if (out_load) begin
            m_status_reg     <= status_reg;
            m_state_reg      <= state_reg;
            m_tool_event_reg <= tool_event_reg;
            m_active_reg     <= active_reg;
            m_repeated_reg   <= repeated_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_current_state  = m_state_reg;
    assign m_tool_event     = m_tool_event_reg;
    assign m_is_active_flag = m_active_reg;
    assign m_crash_repeat   = m_repeated_reg;

endmodule

FILE: dv/crash_recovery_supervisor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crash_recovery_supervisor_top_tb
// Self-checking testbench for the crash-recovery supervisor.
// ----------------------------------------------------------------------------
// Request and crash transactions go in through the s_ channel. A predictor in
// this file tracks the supervisor state, the flags and the crash timestamp
// ring, and queues one expected result per accepted transaction. A monitor
// compares every result transaction on the m_ channel with the oldest entry of
// that queue, field by field. A refused request halts the block until reset,
// and reset is applied only once. For that reason all traffic stays legal
// until the closing test, which makes one illegal request and then checks that
// everything after it is ignored.
// ----------------------------------------------------------------------------
module crash_recovery_supervisor_top_tb;
    import crs_pkg::*;

    localparam int HIST_DEPTH = 4;
    localparam int HIST_SLOT_W = $clog2(HIST_DEPTH);
    localparam int CYCLE_LIMIT = 200000;

    // Register indexes that decode to nothing in the block.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 2'd3;

    // Codes above selftest are not states; the block must refuse them.
    localparam logic [STATE_W-1:0] FIRST_UNDEFINED_STATE = MS_SELFTEST + 4'd1;
    localparam logic [STATE_W-1:0] LAST_STATE_CODE = 4'hF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STATE_W-1:0]  state;
        logic                tool_event;
        logic                active;
        logic                repeated;
    } outcome_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [STAMP_W-1:0]     cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_req_type = REQ_STATE;
    logic [STATE_W-1:0]     s_new_state = MS_IDLE;
    logic                   s_tool_change_busy = 1'b0;
    logic [STAMP_W-1:0]     s_now_time = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STATUS_W-1:0]    m_status;
    logic [STATE_W-1:0]     m_current_state;
    logic                   m_tool_event;
    logic                   m_is_active_flag;
    logic                   m_crash_repeat;

    // Predicted state of the supervisor, mirrored from the reset values.
    logic [STATE_W-1:0]     sup_state = MS_IDLE;
    logic                   sup_active = 1'b0;
    logic                   sup_tool_event = 1'b0;
    logic                   sup_repeated = 1'b0;
    logic                   sup_halted = 1'b0;
    logic [STAMP_W-1:0]     stamp_at [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]  stamp_ok = '0;
    logic [HIST_SLOT_W-1:0] next_slot = '0;

    // Predicted register contents.
    logic                  det_on = 1'b1;
    logic [STAMP_W-1:0]    recent_window = 32'd60;

    outcome_t pending_outcomes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int error_count = 0;
    int items_sent = 0;
    int crashes_sent = 0;
    int results_checked = 0;
    int repeats_seen = 0;
    int halted_sent = 0;
    logic [STATUS_W-1:0] fault_status = STATUS_OK;
    logic [STAMP_W-1:0]  job_clock = '0;

    crash_recovery_supervisor_top #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_new_state(s_new_state),
        .s_tool_change_busy(s_tool_change_busy),
        .s_now_time(s_now_time),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_current_state(m_current_state),
        .m_tool_event(m_tool_event),
        .m_is_active_flag(m_is_active_flag),
        .m_crash_repeat(m_crash_repeat)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // The result side stalls at the rate of the current test.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Decides a state request against the predicted state without changing
    // it. The returned record holds the status and, for a legal request, the
    // state and flags that follow. wipe reports a jump to idle or selftest,
    // which also clears the crash history.
    function automatic outcome_t judge_request(input logic [STATE_W-1:0] ns,
                                               input logic busy,
                                               output logic wipe);
        outcome_t v;
        logic     armed;
        v.status = STATUS_OK;
        v.state = ns;
        v.tool_event = sup_tool_event;
        v.active = sup_active;
        v.repeated = sup_repeated;
        wipe = 1'b0;
        armed = (sup_state == MS_PRINTING) && sup_active;
        if (ns == sup_state) begin
            v.status = STATUS_SAME;
        end else begin
            case (ns)
                MS_IDLE, MS_SELFTEST: begin
                    wipe = 1'b1;
                    v.repeated = 1'b0;
                    v.active = 1'b0;
                end
                MS_STALL: begin
                    if (!armed || !det_on) v.status = STATUS_NOT_ACTIVE;
                    v.tool_event = busy;
                end
                MS_POWER: begin
                    v.tool_event = busy;
                end
                MS_TOOLFALL, MS_TOOLCRASH: begin
                    if (!armed) v.status = STATUS_NOT_ACTIVE;
                    v.tool_event = 1'b1;
                end
                MS_HOMEFAIL: begin
                    if (!armed) v.status = STATUS_NOT_ACTIVE;
                    v.tool_event = 1'b0;
                end
                MS_WAIT: begin
                    if (sup_state != MS_PRINTING && sup_state != MS_TOOLCRASH
                        && sup_state != MS_HOMEFAIL)
                        v.status = STATUS_INVALID;
                end
                MS_RECOVERY: begin
                    if (sup_state != MS_PRINTING && sup_state != MS_STALL
                        && sup_state != MS_TOOLFALL && sup_state != MS_POWER)
                        v.status = STATUS_INVALID;
                end
                MS_REPLAY: begin
                    if (sup_state != MS_RECOVERY) v.status = STATUS_INVALID;
                    v.active = 1'b1;
                end
                MS_PRINTING: begin
                    if (sup_state != MS_RECOVERY && sup_state != MS_WAIT
                        && sup_state != MS_IDLE && sup_state != MS_REPLAY)
                        v.status = STATUS_INVALID;
                    v.repeated = 1'b0;
                    if (sup_state != MS_REPLAY) v.active = 1'b1;
                end
                default: begin
                    v.status = STATUS_INVALID;
                end
            endcase
        end
        return v;
    endfunction

    // Advances the predicted supervisor by one accepted transaction and
    // returns the result that the block must produce for it.
    function automatic outcome_t predict_outcome(input logic kind,
                                                 input logic [STATE_W-1:0] ns,
                                                 input logic busy,
                                                 input logic [STAMP_W-1:0] now);
        outcome_t           o;
        logic               wipe;
        logic [STAMP_W-1:0] age;
        int                 recent;
        o.status = STATUS_OK;
        if (sup_halted) begin
            o.status = STATUS_HALTED;
        end else if (kind == REQ_CRASH) begin
            // Age out stale stamps; a full ring of recent ones is a repeat.
            recent = 0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                age = now - stamp_at[HIST_SLOT_W'(i)];
                if (stamp_ok[HIST_SLOT_W'(i)] && age <= recent_window) recent++;
                else stamp_ok[HIST_SLOT_W'(i)] = 1'b0;
            end
            if (recent == HIST_DEPTH) sup_repeated = 1'b1;
            stamp_at[next_slot] = now;
            stamp_ok[next_slot] = 1'b1;
            next_slot = (next_slot == HIST_SLOT_W'(HIST_DEPTH - 1)) ? '0
                      : next_slot + HIST_SLOT_W'(1);
        end else begin
            o = judge_request(ns, busy, wipe);
            if (o.status == STATUS_OK) begin
                sup_state = o.state;
                sup_tool_event = o.tool_event;
                sup_active = o.active;
                sup_repeated = o.repeated;
                if (wipe) begin
                    stamp_ok = '0;
                    next_slot = '0;
                end
            end else begin
                sup_halted = 1'b1;
            end
        end
        o.state = sup_state;
        o.tool_event = sup_tool_event;
        o.active = sup_active;
        o.repeated = sup_repeated;
        return o;
    endfunction

    // Picks a legal next state at random. Idle and selftest wipe the crash
    // history, so they are drawn less often to let the ring fill up.
    function automatic logic [STATE_W-1:0] pick_next_state();
        logic [STATE_W-1:0] ns;
        logic               unused_wipe;
        outcome_t           v;
        do begin
            ns = STATE_W'($urandom_range(MS_SELFTEST));
            v = judge_request(ns, 1'b0, unused_wipe);
        end while (v.status != STATUS_OK
                   || ((ns == MS_IDLE || ns == MS_SELFTEST) && $urandom_range(3) != 0));
        return ns;
    endfunction

    // Random step of the job clock between crash events: often zero or small,
    // now and then a jump anywhere, which also exercises wrap-around.
    function automatic logic [STAMP_W-1:0] next_job_step();
        case ($urandom_range(9))
            0, 1: return '0;
            2: return $urandom;
            default: return $urandom_range(40);
        endcase
    endfunction

    // Sends one transaction. Valid stays high from one transaction to the
    // next unless the sender decides to idle first, so it is never dropped and
    // raised again inside one time step.
    task automatic send_item(input logic kind, input logic [STATE_W-1:0] ns,
                             input logic busy, input logic [STAMP_W-1:0] now);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_new_state <= ns;
        s_tool_change_busy <= busy;
        s_now_time <= now;
        do @(posedge aclk); while (!s_ready);
        pending_outcomes.push_back(predict_outcome(kind, ns, busy, now));
        items_sent++;
        if (kind == REQ_CRASH) crashes_sent++;
    endtask

    // Lowers valid and waits until every expected result has come back, so
    // that the block is idle afterwards.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_outcomes.size() != 0);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [STAMP_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (index)
            CFG_DETECTION_ENABLED: det_on = data[0];
            CFG_HISTORY_WINDOW: recent_window = data;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Every accepted result is matched against the oldest expectation.
    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result transaction: status %0d, state %0d",
                       m_status, m_current_state);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("current_state", 32'(want.state), 32'(m_current_state));
                check_field("tool_event", 32'(want.tool_event), 32'(m_tool_event));
                check_field("is_active_flag", 32'(want.active), 32'(m_is_active_flag));
                check_field("crash_repeat", 32'(want.repeated), 32'(m_crash_repeat));
                results_checked++;
                if (m_crash_repeat) repeats_seen++;
            end
        end
    end

    // A walk through legal transitions into every state with the reset register values,
    // plus crash events at the time extremes. The last crash burst wraps the
    // job clock and fills the ring with recent stamps, so it must raise the
    // crash repeat flag; selftest then clears it again.
    task automatic test_directed_walk();
        send_item(REQ_STATE, MS_PRINTING, 1'b0, '0);
        send_item(REQ_CRASH, MS_IDLE, 1'b0, 32'd0);
        send_item(REQ_STATE, MS_STALL, 1'b1, '1);
        send_item(REQ_STATE, MS_RECOVERY, 1'b0, '0);
        send_item(REQ_STATE, MS_REPLAY, 1'b1, '0);
        send_item(REQ_STATE, MS_PRINTING, 1'b0, '0);
        send_item(REQ_STATE, MS_TOOLFALL, 1'b0, '0);
        send_item(REQ_STATE, MS_RECOVERY, 1'b1, '0);
        send_item(REQ_STATE, MS_PRINTING, 1'b0, '0);
        send_item(REQ_STATE, MS_TOOLCRASH, 1'b0, '0);
        send_item(REQ_STATE, MS_WAIT, 1'b0, '0);
        send_item(REQ_STATE, MS_PRINTING, 1'b1, '0);
        send_item(REQ_STATE, MS_HOMEFAIL, 1'b1, '0);
        send_item(REQ_STATE, MS_WAIT, 1'b0, '0);
        send_item(REQ_STATE, MS_PRINTING, 1'b0, '0);
        send_item(REQ_STATE, MS_POWER, 1'b1, '0);
        send_item(REQ_STATE, MS_RECOVERY, 1'b0, '0);
        send_item(REQ_STATE, MS_PRINTING, 1'b0, '0);
        send_item(REQ_CRASH, LAST_STATE_CODE, 1'b1, 32'hFFFF_FFFF);
        send_item(REQ_CRASH, MS_SELFTEST, 1'b0, 32'd3);
        send_item(REQ_CRASH, FIRST_UNDEFINED_STATE, 1'b1, 32'd5);
        send_item(REQ_CRASH, MS_PRINTING, 1'b0, 32'd7);
        send_item(REQ_CRASH, MS_STALL, 1'b0, 32'd9);
        send_item(REQ_STATE, MS_SELFTEST, 1'b0, '0);
        send_item(REQ_STATE, MS_POWER, 1'b0, '0);
        send_item(REQ_STATE, MS_IDLE, 1'b1, '0);
    endtask

    // Random legal traffic under one register setting and one idling mix.
    // Crash events carry random state codes and busy bits, which the block
    // must ignore; the spare register indexes get random data as well.
    task automatic test_random_phase(input int count, input int send_pct,
                                     input int recv_pct, input logic detect,
                                     input logic [STAMP_W-1:0] window);
        drain_results();
        write_register(CFG_DETECTION_ENABLED,
                       {31'($urandom_range(32'h7FFF_FFFF)), detect});
        write_register(CFG_HISTORY_WINDOW, window);
        write_register(CFG_SPARE_LOW, $urandom);
        write_register(CFG_SPARE_HIGH, $urandom);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        job_clock = $urandom;
        repeat (count) begin
            if ($urandom_range(99) < 55) begin
                job_clock = job_clock + next_job_step();
                send_item(REQ_CRASH, STATE_W'($urandom_range(LAST_STATE_CODE)),
                          1'($urandom_range(1)), job_clock);
            end else begin
                send_item(REQ_STATE, pick_next_state(), 1'($urandom_range(1)), $urandom);
            end
        end
    endtask

    // One refused request, of a kind chosen at random: same state, an
    // undefined state code, or any other illegal move (trigger while not
    // armed, stall with detection off, invalid transition). Every transaction
    // after it must come back with the halted status.
    task automatic test_halt_after_fault();
        logic [STATE_W-1:0] ns;
        logic               unused_wipe;
        outcome_t           v;
        drain_results();
        write_register(CFG_DETECTION_ENABLED, $urandom);
        write_register(CFG_HISTORY_WINDOW, $urandom_range(100));
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat ($urandom_range(1, 6))
            send_item(REQ_STATE, pick_next_state(), 1'($urandom_range(1)), $urandom);
        case ($urandom_range(3))
            0: ns = sup_state;
            1: ns = STATE_W'(FIRST_UNDEFINED_STATE
                             + $urandom_range(LAST_STATE_CODE - FIRST_UNDEFINED_STATE));
            default: begin
                do begin
                    ns = STATE_W'($urandom_range(MS_SELFTEST));
                    v = judge_request(ns, 1'b0, unused_wipe);
                end while (v.status == STATUS_OK);
            end
        endcase
        v = judge_request(ns, 1'b0, unused_wipe);
        fault_status = v.status;
        send_item(REQ_STATE, ns, 1'($urandom_range(1)), $urandom);
        repeat (12) begin
            send_item(1'($urandom_range(1)), STATE_W'($urandom_range(LAST_STATE_CODE)),
                      1'($urandom_range(1)), $urandom);
            halted_sent++;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 52;
        test_directed_walk();
        test_random_phase(140, 38, 52, 1'b1, $urandom_range(30, 120));
        test_random_phase(140, 52, 38, 1'b0, 32'd0);
        test_random_phase(140, 0, 0, 1'b1, 32'hFFFF_FFFF);
        test_halt_after_fault();
        drain_results();
        // Give a late or duplicate result time to show up.
        repeat (HIST_DEPTH + 4) @(posedge aclk);
        $display("Checked %0d results for %0d transactions, %0d of them crash events;",
                 results_checked, items_sent, crashes_sent);
        $display("crash repeat flag seen %0d times, closing fault status %0d, %0d halted after.",
                 repeats_seen, fault_status, halted_sent);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
